### rtl/cle_pkg.sv
// Shared types and character constants for the console line editor.
`timescale 1ns / 1ps

package cle_pkg;

    typedef logic [7:0] t_byte;

    localparam t_byte CH_CR  = 8'h0D;
    localparam t_byte CH_LF  = 8'h0A;
    localparam t_byte CH_TAB = 8'h09;
    localparam t_byte CH_SP  = 8'h20;
    localparam t_byte CH_BS  = 8'h08;
    localparam t_byte CH_DEL = 8'h7F;

    // out_limit register: width, reset value and saturation range
    localparam int          LIMIT_W     = 7;
    localparam logic [6:0]  LIMIT_RESET = 7'd64;
    localparam logic [6:0]  LIMIT_MIN   = 7'd2;
    localparam logic [6:0]  LIMIT_MAX   = 7'd64;

    // emitted length never exceeds LIMIT_MAX - 1, so a result index fits here
    localparam int          KW          = 6;

endpackage

### rtl/cle_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/console_line_editor.sv
// Console line editor: terminal byte input, echo and completed-line output.
// Sequence: an ordinary byte is stored, then its echo request is registered from S_ECHO;
// backspace gives its 3 echo requests from S_BS; a line end checks one line RAM entry per
// S_TRIM step (trailing blanks plus the last kept character), starts the read in S_START,
// then gives one result per S_EMIT step while the output slot is free.
// One byte at a time: a new byte is taken only back in S_IDLE, once its last result is registered.
// Reset (synchronous, active low) empties the line and sets out_limit to 64;
// the line RAM is not cleared, since only written entries are ever used.
`timescale 1ns / 1ps

module console_line_editor
    import cle_pkg::*;
#(
    parameter int LINE_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_data,
    input  logic               i_rx_valid,
    output logic               o_rx_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_echo_valid,
    output logic [7:0]         o_echo_byte,
    output logic               o_line_valid,
    output logic [7:0]         o_line_char,
    output logic               o_line_end,
    output logic               o_run_last
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = (AW > LIMIT_W) ? AW : LIMIT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ECHO  = 3'd1;
    localparam logic [2:0] S_BS    = 3'd2;
    localparam logic [2:0] S_TRIM  = 3'd3;
    localparam logic [2:0] S_START = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [AW-1:0]      r_fill, n_fill;
    logic [AW-1:0]      r_len, n_len;
    logic [KW-1:0]      r_k, n_k;
    logic [KW-1:0]      r_emit, n_emit;
    logic [KW-1:0]      r_cnt, n_cnt;
    t_byte              r_byte, n_byte;
    logic [LIMIT_W-1:0] r_limit;

    logic  r_out_valid, n_out_valid;
    logic  r_echo_valid, n_echo_valid;
    t_byte r_echo_byte, n_echo_byte;
    logic  r_line_valid, n_line_valid;
    t_byte r_line_char, n_line_char;
    logic  r_line_end, n_line_end;
    logic  r_run_last, n_run_last;

    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    t_byte         ram_rdata;

    logic               slot_free;
    logic               blank;
    logic               trim_done;
    logic [AW-1:0]      fin_len;
    logic [LIMIT_W-1:0] lim_sat;
    logic [CW-1:0]      len_ext;
    logic [CW-1:0]      lim_ext;
    logic [KW-1:0]      emit_c;
    logic               k_emit;
    logic               k_last;

    cle_ram #(
        .WIDTH(8),
        .DEPTH(LINE_DEPTH)
    ) u_line_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_fill),
        .i_wdata(i_rx_byte),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_rx_ready = (r_state == S_IDLE);

    // trailing blank walk: RAM data is the entry at r_len-1
    assign blank     = (ram_rdata == CH_SP) || (ram_rdata == CH_TAB);
    assign fin_len   = blank ? (r_len - AW'(1)) : r_len;
    assign trim_done = !blank || (r_len == AW'(1));

    assign lim_sat = (r_limit < LIMIT_MIN) ? LIMIT_MIN :
                     (r_limit > LIMIT_MAX) ? LIMIT_MAX : r_limit;
    assign len_ext = CW'(fin_len);
    assign lim_ext = CW'(lim_sat - LIMIT_W'(1));
    assign emit_c  = KW'((len_ext < lim_ext) ? len_ext : lim_ext);

    assign k_emit = (r_k < r_emit);
    assign k_last = (r_k + KW'(1)) == r_cnt;

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_len        = r_len;
        n_k          = r_k;
        n_emit       = r_emit;
        n_cnt        = r_cnt;
        n_byte       = r_byte;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_echo_valid = r_echo_valid;
        n_echo_byte  = r_echo_byte;
        n_line_valid = r_line_valid;
        n_line_char  = r_line_char;
        n_line_end   = r_line_end;
        n_run_last   = r_run_last;
        ram_we       = 1'b0;
        ram_raddr    = r_fill - AW'(1);

        case (r_state)
            S_IDLE: begin
                if (i_rx_valid) begin
                    if (i_rx_byte inside {CH_CR, CH_LF}) begin
                        if (r_fill != '0) begin
                            n_len   = r_fill;
                            n_state = S_TRIM;
                        end
                    end else if (i_rx_byte inside {CH_BS, CH_DEL}) begin
                        if (r_fill != '0) begin
                            n_fill  = r_fill - AW'(1);
                            n_k     = '0;
                            n_state = S_BS;
                        end
                    end else if (r_fill < AW'(LINE_DEPTH - 1)) begin
                        ram_we  = 1'b1;
                        n_fill  = r_fill + AW'(1);
                        n_byte  = i_rx_byte;
                        n_state = S_ECHO;
                    end
                end
            end
            S_ECHO: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_echo_valid = 1'b1;
                    n_echo_byte  = r_byte;
                    n_line_valid = 1'b0;
                    n_line_char  = '0;
                    n_line_end   = 1'b0;
                    n_run_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_BS: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_echo_valid = 1'b1;
                    n_echo_byte  = (r_k == KW'(1)) ? CH_SP : CH_BS;
                    n_line_valid = 1'b0;
                    n_line_char  = '0;
                    n_line_end   = 1'b0;
                    n_run_last   = (r_k == KW'(2));
                    n_k          = r_k + KW'(1);
                    if (r_k == KW'(2)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_TRIM: begin
                // prefetch the next entry down while this one is checked
                ram_raddr = r_len - AW'(2);
                n_len     = fin_len;
                if (trim_done) begin
                    n_fill  = '0;
                    n_emit  = emit_c;
                    n_cnt   = (emit_c > KW'(2)) ? emit_c : KW'(2);
                    n_k     = '0;
                    n_state = S_START;
                end
            end
            S_START: begin
                ram_raddr = '0;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                // hold the read address while the output slot is stalled
                ram_raddr = AW'(r_k);
                if (slot_free) begin
                    ram_raddr    = AW'(r_k + KW'(1));
                    n_out_valid  = 1'b1;
                    n_echo_valid = (r_k < KW'(2));
                    n_echo_byte  = (r_k == KW'(0)) ? CH_CR :
                                   (r_k == KW'(1)) ? CH_LF : 8'h00;
                    n_line_valid = k_emit;
                    n_line_char  = k_emit ? ram_rdata : 8'h00;
                    n_line_end   = k_emit && ((r_k + KW'(1)) == r_emit);
                    n_run_last   = k_last;
                    n_k          = r_k + KW'(1);
                    if (k_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_limit     <= LIMIT_RESET;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len        <= n_len;
        r_k          <= n_k;
        r_emit       <= n_emit;
        r_cnt        <= n_cnt;
        r_byte       <= n_byte;
        r_echo_valid <= n_echo_valid;
        r_echo_byte  <= n_echo_byte;
        r_line_valid <= n_line_valid;
        r_line_char  <= n_line_char;
        r_line_end   <= n_line_end;
        r_run_last   <= n_run_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_echo_valid = r_echo_valid;
    assign o_echo_byte  = r_echo_byte;
    assign o_line_valid = r_line_valid;
    assign o_line_char  = r_line_char;
    assign o_line_end   = r_line_end;
    assign o_run_last   = r_run_last;

endmodule

### rtl/cle_checker.sv
// Port-level assertions for the console line editor, bound to the top level.
`timescale 1ns / 1ps

module cle_checker
    import cle_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  o_rx_ready,
    input logic  o_out_valid,
    input logic  i_out_ready,
    input logic  o_echo_valid,
    input t_byte o_echo_byte,
    input logic  o_line_valid,
    input t_byte o_line_char,
    input logic  o_line_end,
    input logic  o_run_last
);

    // a stalled result request holds with its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_echo_byte)
            && $stable(o_line_char) && $stable(o_run_last))
        else $error("result request dropped or changed while stalled");

    // a new byte is taken only once every earlier result but the last is out
    a_ready_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_ready && o_out_valid |-> o_run_last)
        else $error("input ready while a byte still has results pending");

    // past the CR LF echo, every result carries a line character
    a_no_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_echo_valid |-> o_line_valid)
        else $error("result with neither echo nor line character");

    // the end mark falls on a line character, next to a CR or LF echo at most
    a_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_end |-> o_line_valid
            && !(o_echo_valid && o_echo_byte != CH_CR && o_echo_byte != CH_LF))
        else $error("line end mark outside a line character");

endmodule

bind console_line_editor cle_checker u_cle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_rx_ready  (o_rx_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_echo_valid(o_echo_valid),
    .o_echo_byte (o_echo_byte),
    .o_line_valid(o_line_valid),
    .o_line_char (o_line_char),
    .o_line_end  (o_line_end),
    .o_run_last  (o_run_last)
);

### tb/tb_top.sv
// Self-checking testbench for the console line editor: directed script, then random phases.
`timescale 1ns / 1ps

module tb_top;
    import cle_pkg::*;

    localparam int LINE_DEPTH = 64;
    localparam int SETTLE     = 2 * LINE_DEPTH + 8;
    localparam int HOLD_AT    = 200;
    localparam int HOLD_LEN   = 400;
    localparam int CYCLE_CAP  = 2000000;
    localparam int PHASE_REQS = 30;

    typedef struct packed {
        logic  echo_valid;
        t_byte echo_byte;
        logic  line_valid;
        t_byte line_char;
        logic  line_end;
        logic  run_last;
    } t_term_out;

    typedef enum logic [2:0] {
        ROW_CFG,    // write out_limit
        ROW_PRED,   // result taken from the line model
        ROW_ECHO,   // plain echo of the byte
        ROW_ERASE,  // backspace, space, backspace
        ROW_NONE    // no result at all
    } t_row_kind;

    typedef struct packed {
        t_row_kind kind;
        t_byte     data;
    } t_row;

    logic               i_clk;
    logic               rst_n;
    logic               cfg_we;
    logic [LIMIT_W-1:0] cfg_data;
    logic               rx_valid;
    t_byte              rx_byte;
    logic               out_ready;
    logic               o_rx_ready;
    logic               o_out_valid;
    logic               o_echo_valid;
    logic [7:0]         o_echo_byte;
    logic               o_line_valid;
    logic [7:0]         o_line_char;
    logic               o_line_end;
    logic               o_run_last;

    // line model state
    t_byte              line_buf [LINE_DEPTH];
    int                 line_fill;
    logic [LIMIT_W-1:0] line_limit;

    t_term_out term_expected [$];
    t_row      script [$];

    int  err_cnt;
    int  sent_cnt;
    int  busy_cnt;
    int  out_cnt;
    int  lines_seen;
    int  cfg_cnt;
    int  cycles;
    bit  no_idle;

    console_line_editor #(
        .LINE_DEPTH(LINE_DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_rx_valid  (rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx_byte   (rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_echo_valid(o_echo_valid),
        .o_echo_byte (o_echo_byte),
        .o_line_valid(o_line_valid),
        .o_line_char (o_line_char),
        .o_line_end  (o_line_end),
        .o_run_last  (o_run_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_error(input string msg);
        err_cnt++;
        $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    function automatic void put_out(input bit keep, input logic ev, input t_byte eb,
                                    input logic lv, input t_byte lc, input logic le,
                                    input logic rl);
        t_term_out r;
        r.echo_valid = ev;
        r.echo_byte  = eb;
        r.line_valid = lv;
        r.line_char  = lc;
        r.line_end   = le;
        r.run_last   = rl;
        if (keep)
            term_expected.push_back(r);
    endfunction

    // Line editor behavior for one received byte; returns the number of results.
    function automatic int edit_line(input t_byte b, input bit keep);
        int len;
        int lim;
        int emit;
        int n;
        n = 0;
        if (b == CH_CR || b == CH_LF) begin
            if (line_fill > 0) begin
                len = line_fill;
                while (len > 0 && (line_buf[len-1] == CH_SP || line_buf[len-1] == CH_TAB))
                    len--;
                line_fill = 0;
                lim = int'(line_limit);
                if (lim < int'(LIMIT_MIN)) lim = int'(LIMIT_MIN);
                if (lim > int'(LIMIT_MAX)) lim = int'(LIMIT_MAX);
                emit = (len < lim - 1) ? len : lim - 1;
                n = (emit > 2) ? emit : 2;
                for (int k = 0; k < n; k++)
                    put_out(keep, k < 2, (k == 0) ? CH_CR : ((k == 1) ? CH_LF : 8'h00),
                            k < emit, (k < emit) ? line_buf[k] : 8'h00,
                            k + 1 == emit, k + 1 == n);
            end
        end else if (b == CH_DEL || b == CH_BS) begin
            if (line_fill > 0) begin
                line_fill--;
                put_out(keep, 1'b1, CH_BS, 1'b0, 8'h00, 1'b0, 1'b0);
                put_out(keep, 1'b1, CH_SP, 1'b0, 8'h00, 1'b0, 1'b0);
                put_out(keep, 1'b1, CH_BS, 1'b0, 8'h00, 1'b0, 1'b1);
                n = 3;
            end
        end else if (line_fill < LINE_DEPTH - 1) begin
            line_buf[line_fill] = b;
            line_fill++;
            put_out(keep, 1'b1, b, 1'b0, 8'h00, 1'b0, 1'b1);
            n = 1;
        end
        return n;
    endfunction

    task automatic send_byte(input t_byte b, input bit keep);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        sent_cnt++;
        if (edit_line(b, keep) > 0)
            busy_cnt++;
    endtask

    // drain the block, let a silent request finish, then write the register
    task automatic set_out_limit(input logic [LIMIT_W-1:0] v);
        rx_valid <= 1'b0;
        while (term_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we     <= 1'b0;
        line_limit  = v;
        cfg_cnt++;
    endtask

    task automatic send_line(input int len);
        t_byte c;
        int    blanks;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                c = $urandom_range(0, 1) ? CH_BS : CH_DEL;
            end else if ($urandom_range(0, 5) == 0) begin
                do c = 8'($urandom_range(0, 255));
                while (c == CH_CR || c == CH_LF || c == CH_BS || c == CH_DEL);
            end else begin
                c = 8'($urandom_range(8'h21, 8'h7E));
            end
            send_byte(c, 1'b1);
        end
        blanks = $urandom_range(0, 4);
        for (int i = 0; i < blanks; i++)
            send_byte($urandom_range(0, 1) ? CH_SP : CH_TAB, 1'b1);
        send_byte($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b1);
    endtask

    // result checker
    initial begin
        t_term_out got;
        t_term_out want;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && out_ready) begin
                got = {o_echo_valid, o_echo_byte, o_line_valid, o_line_char,
                       o_line_end, o_run_last};
                if (term_expected.size() == 0) begin
                    flag_error($sformatf("unexpected result ev=%b eb=%h lv=%b lc=%h le=%b rl=%b",
                               got.echo_valid, got.echo_byte, got.line_valid,
                               got.line_char, got.line_end, got.run_last));
                end else begin
                    want = term_expected.pop_front();
                    out_cnt++;
                    if (want.line_end)
                        lines_seen++;
                    if (got.echo_valid !== want.echo_valid || got.echo_byte !== want.echo_byte ||
                        got.line_valid !== want.line_valid || got.line_char !== want.line_char ||
                        got.line_end !== want.line_end || got.run_last !== want.run_last)
                        flag_error($sformatf(
                            "result %0d: ev %b/%b eb %h/%h lv %b/%b lc %h/%h le %b/%b rl %b/%b",
                            out_cnt, got.echo_valid, want.echo_valid, got.echo_byte,
                            want.echo_byte, got.line_valid, want.line_valid, got.line_char,
                            want.line_char, got.line_end, want.line_end, got.run_last,
                            want.run_last));
                end
            end
        end
    end

    // output side: random stalls per result, one long hold-off
    initial begin
        int stall;
        int taken;
        taken = 0;
        wait (rst_n === 1'b1);
        forever begin
            if (taken == HOLD_AT) begin
                out_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
            end
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            taken++;
        end
    end

    // watchdog
    initial begin
        cycles = 0;
        while (cycles < CYCLE_CAP) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("console_line_editor test failed");
        $finish;
    end

    initial begin
        logic [LIMIT_W-1:0] phase_limits [8];
        int                 goal;
        int                 pick;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_data  = '0;
        rx_valid  = 1'b0;
        rx_byte   = '0;
        out_ready = 1'b0;
        no_idle   = 1'b0;
        err_cnt   = 0;
        sent_cnt  = 0;
        busy_cnt  = 0;
        out_cnt   = 0;
        lines_seen = 0;
        cfg_cnt   = 0;
        line_fill = 0;
        line_limit = LIMIT_RESET;
        foreach (line_buf[i]) line_buf[i] = 8'h00;

        phase_limits = '{7'd64, 7'd1, 7'd2, 7'd127, 7'd65, 7'd63, 7'd5, 7'd0};
        phase_limits[6] = 7'($urandom_range(3, 62));

        script.push_back({ROW_NONE,  CH_CR});   // line end on empty line
        script.push_back({ROW_NONE,  CH_BS});   // backspace on empty line
        script.push_back({ROW_NONE,  CH_DEL});
        script.push_back({ROW_ECHO,  8'h61});
        script.push_back({ROW_ECHO,  8'h00});
        script.push_back({ROW_ECHO,  8'hFF});
        script.push_back({ROW_ERASE, CH_DEL});
        script.push_back({ROW_ECHO,  CH_SP});
        script.push_back({ROW_ECHO,  CH_TAB});
        script.push_back({ROW_PRED,  CH_CR});   // trailing blanks trimmed
        script.push_back({ROW_ECHO,  CH_SP});
        script.push_back({ROW_ECHO,  CH_TAB});
        script.push_back({ROW_PRED,  CH_LF});   // blank after trimming: echo only
        script.push_back({ROW_CFG,   8'h00});   // saturates up to 2
        script.push_back({ROW_ECHO,  8'h78});
        script.push_back({ROW_ECHO,  8'h79});
        script.push_back({ROW_PRED,  CH_CR});
        script.push_back({ROW_CFG,   8'h7F});   // saturates down to 64
        script.push_back({ROW_ECHO,  8'h70});
        script.push_back({ROW_ERASE, CH_BS});
        script.push_back({ROW_ECHO,  8'h71});
        script.push_back({ROW_ECHO,  8'h72});
        script.push_back({ROW_PRED,  CH_LF});
        script.push_back({ROW_CFG,   8'h03});
        script.push_back({ROW_ECHO,  8'h41});
        script.push_back({ROW_ECHO,  8'h42});
        script.push_back({ROW_ECHO,  8'h43});
        script.push_back({ROW_PRED,  CH_CR});   // cut to out_limit-1 characters

        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            case (script[i].kind)
                ROW_CFG:  set_out_limit(script[i].data[LIMIT_W-1:0]);
                ROW_PRED: send_byte(script[i].data, 1'b1);
                default: begin
                    send_byte(script[i].data, 1'b0);
                    if (script[i].kind == ROW_ECHO) begin
                        put_out(1'b1, 1'b1, script[i].data, 1'b0, 8'h00, 1'b0, 1'b1);
                    end else if (script[i].kind == ROW_ERASE) begin
                        put_out(1'b1, 1'b1, CH_BS, 1'b0, 8'h00, 1'b0, 1'b0);
                        put_out(1'b1, 1'b1, CH_SP, 1'b0, 8'h00, 1'b0, 1'b0);
                        put_out(1'b1, 1'b1, CH_BS, 1'b0, 8'h00, 1'b0, 1'b1);
                    end
                end
            endcase
        end

        for (int ph = 0; ph < 8; ph++) begin
            set_out_limit(phase_limits[ph]);
            no_idle = (ph == 3);
            // overfill the store right away so full-store drops show up early
            if (ph == 0)
                send_line(80);
            goal = busy_cnt + PHASE_REQS;
            while (busy_cnt < goal) begin
                pick = $urandom_range(0, 9);
                if (pick <= 6) begin
                    send_line(($urandom_range(0, 7) == 0) ? $urandom_range(55, 75)
                                                          : $urandom_range(0, 12));
                end else if (pick == 7) begin
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), 1'b1);
                end else if (pick == 8) begin
                    repeat ($urandom_range(1, 5))
                        send_byte($urandom_range(0, 1) ? CH_BS : CH_DEL, 1'b1);
                end else begin
                    repeat ($urandom_range(1, 4))
                        send_byte($urandom_range(0, 1) ? CH_SP : CH_TAB, 1'b1);
                    send_byte($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b1);
                end
            end
        end

        rx_valid <= 1'b0;
        while (term_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Covered %0d received bytes (%0d with output), %0d results checked,",
                 sent_cnt, busy_cnt, out_cnt);
        $display("%0d completed lines emitted, %0d out_limit settings, %0d errors.",
                 lines_seen, cfg_cnt, err_cnt);
        if (err_cnt == 0)
            $display("console_line_editor test passed");
        else
            $display("console_line_editor test failed");
        $finish;
    end

endmodule
